// File: rtl/thc_pkg.sv
// shared types and constants for the torch height controller
package thc_pkg;

  localparam int unsigned COUNTS_W  = 12;
  localparam int unsigned FILTER_W  = 28;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned TIMER_W   = 17;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned STEPS_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [TIMER_W-1:0]    TIMER_MAX        = '1;
  localparam logic [WEIGHT_W:0]     WEIGHT_ONE       = {1'b1, {WEIGHT_W{1'b0}}};
  localparam logic [COUNTS_W-1:0]   SETPOINT_RESET   = 12'd0;
  localparam logic [COUNTS_W-1:0]   MIN_SETPT_RESET  = 12'd593;
  localparam logic [DELAY_W-1:0]    ARC_DELAY_RESET  = 16'd0;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET     = 16'd0;
  localparam logic [STEPS_W-1:0]    STEPS_RESET      = 8'd1;

  // register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS        = 3'd4;

  // kind of beat, decoded from func
  typedef enum logic {
    ITEM_SAMPLE  = 1'b0,
    ITEM_CONTROL = 1'b1
  } item_kind_t;

  // one classified item as held in the queue
  typedef struct packed {
    item_kind_t             kind;
    logic [COUNTS_W-1:0]    adc_sample;
    logic                   plasma_on;
    logic                   suspended;
    logic [ELAPSED_W-1:0]   elapsed_ms;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// File: rtl/torch_height_control.sv
// top level of the plasma torch height controller
// Plasma torch height controller. Sample beats (func 0) fold a 12-bit arc voltage reading
// into an exponential average, control beats (func 1) time the arc and drive a bang-bang
// Z step request; every beat gives one result beat. The block takes one beat per clock
// cycle while item_stall is low: the filter multiplies, the timer add and the setpoint
// compare for an item are combinational at the back end, with the loop state updated as
// the result is registered. An accepted beat is first written into the queue, then its
// result is registered at the result port. A queue of QUEUE_DEPTH entries (at least 2)
// sits between the input and the back end, so the input keeps taking beats while a
// result waits on result_stall, until the queue fills. Settings are written by the user
// through cfg_write, cfg_index and cfg_data only while the block is idle; not enforced.
module torch_height_control import thc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 func,
  input  logic [COUNTS_W-1:0]  adc_sample,
  input  logic                 plasma_on,
  input  logic                 suspended,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [COUNTS_W-1:0]  filtered_counts,
  output logic [STEPS_W-1:0]   step_request,
  output logic                 step_down,
  output logic                 loop_running,
  output logic                 plasma_disable
);

  queue_head_t head;
  logic        pop;

  // front end and queue
  thc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .adc_sample (adc_sample),
    .plasma_on  (plasma_on),
    .suspended  (suspended),
    .elapsed_ms (elapsed_ms),
    .head       (head),
    .pop        (pop)
  );

  // back end
  thc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .head            (head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .filtered_counts (filtered_counts),
    .step_request    (step_request),
    .step_down       (step_down),
    .loop_running    (loop_running),
    .plasma_disable  (plasma_disable)
  );

endmodule

// File: rtl/thc_front.sv
// input side: accepts item beats, classifies them and queues them for the back end
module thc_front import thc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 func,
  input  logic [COUNTS_W-1:0]  adc_sample,
  input  logic                 plasma_on,
  input  logic                 suspended,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  output queue_head_t          head,
  input  logic                 pop
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  item_t            store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;
  item_t            decoded;

  // classify the incoming beat
  always_comb begin
    decoded.kind       = func ? ITEM_CONTROL : ITEM_SAMPLE;
    decoded.adc_sample = adc_sample;
    decoded.plasma_on  = plasma_on;
    decoded.suspended  = suspended;
    decoded.elapsed_ms = elapsed_ms;
  end

  assign item_stall = (count == FULL_CNT);
  assign push       = item_valid && !item_stall;
  assign do_pop     = pop && (count != '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= decoded;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = store[rd_ptr];

endmodule

// File: rtl/thc_back.sv
// back end: settings registers, filter, arc timer, bang-bang loop and result register
module thc_back import thc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  queue_head_t          head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [COUNTS_W-1:0]  filtered_counts,
  output logic [STEPS_W-1:0]   step_request,
  output logic                 step_down,
  output logic                 loop_running,
  output logic                 plasma_disable
);

  logic [COUNTS_W-1:0] setpoint;
  logic [COUNTS_W-1:0] min_setpoint;
  logic [DELAY_W-1:0]  arc_delay;
  logic [WEIGHT_W-1:0] weight;
  logic [STEPS_W-1:0]  steps;

  logic [FILTER_W-1:0] filtered_voltage;
  logic                running_flag;
  logic [TIMER_W-1:0]  arc_timer;
  logic [STEPS_W-1:0]  step_count;
  logic                direction_down;

  logic [FILTER_W-1:0] filtered_voltage_next;
  logic                running_flag_next;
  logic [TIMER_W-1:0]  arc_timer_next;
  logic [STEPS_W-1:0]  step_count_next;
  logic                direction_down_next;
  logic                disable_next;

  logic                    advance;
  logic [WEIGHT_W:0]       new_weight;
  logic [COUNTS_W+WEIGHT_W:0] new_part;
  logic [FILTER_W+WEIGHT_W-1:0] old_part;
  logic [FILTER_W+1:0]     blended;
  logic [TIMER_W:0]        timer_sum;
  logic                    arc_enabled;
  logic [FILTER_W-1:0]     target;

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= SETPOINT_RESET;
      min_setpoint <= MIN_SETPT_RESET;
      arc_delay    <= ARC_DELAY_RESET;
      weight       <= WEIGHT_RESET;
      steps        <= STEPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETPOINT:     setpoint     <= cfg_data[COUNTS_W-1:0];
        REG_MIN_SETPOINT: min_setpoint <= cfg_data[COUNTS_W-1:0];
        REG_ARC_DELAY:    arc_delay    <= cfg_data[DELAY_W-1:0];
        REG_WEIGHT:       weight       <= cfg_data[WEIGHT_W-1:0];
        REG_STEPS:        steps        <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // take the queue head whenever the result register is free or being drained
  assign advance = head.valid && (!result_valid || !result_stall);
  assign pop     = advance;

  // exponential filter: sample weighted by one minus w, old average by w
  assign new_weight = WEIGHT_ONE - {1'b0, weight};
  assign new_part   = head.item.adc_sample * new_weight;
  assign old_part   = filtered_voltage * weight;
  assign blended    = {1'b0, new_part} + {2'b00, old_part[FILTER_W+WEIGHT_W-1:WEIGHT_W]};

  // arc timer, saturating add
  assign timer_sum   = {1'b0, arc_timer} + {{(TIMER_W+1-ELAPSED_W){1'b0}}, head.item.elapsed_ms};
  assign arc_enabled = head.item.plasma_on && !head.item.suspended && (setpoint > min_setpoint);
  assign target      = {setpoint, {FRAC_W{1'b0}}};

  // next state for the item at the head of the queue
  always_comb begin
    filtered_voltage_next = filtered_voltage;
    running_flag_next     = running_flag;
    arc_timer_next        = arc_timer;
    step_count_next       = step_count;
    direction_down_next   = direction_down;
    disable_next          = 1'b0;
    unique case (head.item.kind)
      ITEM_SAMPLE: begin
        if (running_flag) begin
          filtered_voltage_next = blended[FILTER_W-1:0];
        end else begin
          filtered_voltage_next = {head.item.adc_sample, {FRAC_W{1'b0}}};
        end
      end
      ITEM_CONTROL: begin
        disable_next = head.item.suspended;
        if (arc_enabled) begin
          arc_timer_next    = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
          running_flag_next = arc_timer_next > {1'b0, arc_delay};
        end else begin
          arc_timer_next    = '0;
          running_flag_next = 1'b0;
          step_count_next   = '0;
        end
        if (running_flag_next) begin
          if (filtered_voltage > target) begin
            step_count_next     = steps;
            direction_down_next = 1'b1;
          end else if (filtered_voltage < target) begin
            step_count_next     = steps;
            direction_down_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_voltage <= '0;
      running_flag     <= 1'b0;
      arc_timer        <= '0;
      step_count       <= '0;
      direction_down   <= 1'b0;
    end else if (advance) begin
      filtered_voltage <= filtered_voltage_next;
      running_flag     <= running_flag_next;
      arc_timer        <= arc_timer_next;
      step_count       <= step_count_next;
      direction_down   <= direction_down_next;
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_counts <= filtered_voltage_next[FILTER_W-1:FRAC_W];
      step_request    <= step_count_next;
      step_down       <= direction_down_next;
      loop_running    <= running_flag_next;
      plasma_disable  <= disable_next;
    end
  end

endmodule

// File: dv/torch_height_control_tb.sv
// testbench for the torch height controller: directed and random beats checked on the fly
`timescale 1ns / 1ps

module torch_height_control_tb;
  import thc_pkg::*;

  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_BEATS   = 166;
  localparam int unsigned PAUSE_PHASE   = 3;
  localparam int unsigned LONG_ARC      = 2;
  localparam int unsigned NEVER_ARC     = 4;
  localparam int unsigned DIRECTED_ROWS = 20;

  // settings as held by the block
  typedef struct packed {
    logic [COUNTS_W-1:0] setpoint;
    logic [COUNTS_W-1:0] min_setpoint;
    logic [DELAY_W-1:0]  arc_delay;
    logic [WEIGHT_W-1:0] weight;
    logic [STEPS_W-1:0]  steps;
  } thc_cfg_t;

  // one result beat
  typedef struct packed {
    logic [COUNTS_W-1:0] counts;
    logic [STEPS_W-1:0]  steps;
    logic                down;
    logic                running;
    logic                disable_arc;
  } thc_result_t;

  // directed stimulus row, with an optional typed-in result
  typedef struct packed {
    logic        reconfig;
    thc_cfg_t    cfg;
    item_t       beat;
    logic        typed;
    thc_result_t want;
  } dir_row_t;

  localparam thc_cfg_t CFG_RESET = '{SETPOINT_RESET, MIN_SETPT_RESET, ARC_DELAY_RESET,
                                      WEIGHT_RESET, STEPS_RESET};
  localparam thc_cfg_t CFG_HALF  = '{12'd2000, 12'd0, 16'd0, 16'h8000, 8'd255};
  localparam thc_cfg_t CFG_HEAVY = '{12'd4095, 12'd4094, 16'd0, 16'hFFFF, 8'd0};
  localparam thc_cfg_t CFG_SLOW  = '{12'd1, 12'd0, 16'hFFFF, 16'd0, 8'd128};

  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset settings: arc can never be enabled
    '{1'b0, CFG_RESET, '{ITEM_SAMPLE,  12'd0,    1'b0, 1'b0, 10'd0},
      1'b1, '{12'd0,    8'd0,   1'b0, 1'b0, 1'b0}},
    '{1'b0, CFG_RESET, '{ITEM_SAMPLE,  12'd4095, 1'b1, 1'b1, 10'd1023},
      1'b1, '{12'd4095, 8'd0,   1'b0, 1'b0, 1'b0}},
    '{1'b0, CFG_RESET, '{ITEM_CONTROL, 12'hA5A,  1'b1, 1'b0, 10'd1023},
      1'b1, '{12'd4095, 8'd0,   1'b0, 1'b0, 1'b0}},
    '{1'b0, CFG_RESET, '{ITEM_CONTROL, 12'h5A5,  1'b1, 1'b1, 10'd0},
      1'b1, '{12'd4095, 8'd0,   1'b0, 1'b0, 1'b1}},
    // arc start with no delay: zero elapsed keeps the loop off, then it runs
    '{1'b1, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd0},
      1'b1, '{12'd4095, 8'd0,   1'b0, 1'b0, 1'b0}},
    '{1'b0, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd1},
      1'b1, '{12'd4095, 8'd255, 1'b1, 1'b1, 1'b0}},
    '{1'b0, CFG_HALF,  '{ITEM_SAMPLE,  12'd0,    1'b0, 1'b0, 10'd0},   1'b0, '0},
    '{1'b0, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd5},   1'b0, '0},
    '{1'b0, CFG_HALF,  '{ITEM_SAMPLE,  12'd0,    1'b0, 1'b0, 10'd0},   1'b0, '0},
    '{1'b0, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd5},   1'b0, '0},
    // plasma off drops the loop and the request
    '{1'b0, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b0, 1'b0, 10'd7},   1'b0, '0},
    // load equal to the setpoint, then hold on equality
    '{1'b0, CFG_HALF,  '{ITEM_SAMPLE,  12'd2000, 1'b0, 1'b0, 10'd0},   1'b0, '0},
    '{1'b0, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd1},   1'b0, '0},
    '{1'b0, CFG_HALF,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b1, 10'd1023}, 1'b0, '0},
    // heaviest weight and zero steps per correction
    '{1'b1, CFG_HEAVY, '{ITEM_SAMPLE,  12'd4095, 1'b0, 1'b0, 10'd0},   1'b0, '0},
    '{1'b0, CFG_HEAVY, '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd1},   1'b0, '0},
    '{1'b0, CFG_HEAVY, '{ITEM_SAMPLE,  12'd0,    1'b0, 1'b0, 10'd0},   1'b0, '0},
    '{1'b0, CFG_HEAVY, '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd1},   1'b0, '0},
    // longest arc delay
    '{1'b1, CFG_SLOW,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd1023}, 1'b0, '0},
    '{1'b0, CFG_SLOW,  '{ITEM_CONTROL, 12'd0,    1'b1, 1'b0, 10'd1023}, 1'b0, '0}
  };

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  logic                 func         = 1'b0;
  logic [COUNTS_W-1:0]  adc_sample   = '0;
  logic                 plasma_on    = 1'b0;
  logic                 suspended    = 1'b0;
  logic [ELAPSED_W-1:0] elapsed_ms   = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [COUNTS_W-1:0]  filtered_counts;
  logic [STEPS_W-1:0]   step_request;
  logic                 step_down;
  logic                 loop_running;
  logic                 plasma_disable;

  torch_height_control dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .func, .adc_sample, .plasma_on, .suspended, .elapsed_ms,
    .result_valid, .result_stall, .filtered_counts, .step_request, .step_down,
    .loop_running, .plasma_disable
  );

  // controller state mirrored by the testbench
  thc_cfg_t             settings = CFG_RESET;
  logic [FILTER_W-1:0]  avg_fixed = '0;
  logic                 loop_on   = 1'b0;
  logic [TIMER_W-1:0]   arc_ms    = '0;
  logic [STEPS_W-1:0]   steps_held = '0;
  logic                 dir_down  = 1'b0;

  thc_result_t expected_results [$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        failed        = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // advance the mirrored controller by one beat and return its result
  function automatic thc_result_t advance_controller(item_t b);
    thc_result_t r;
    logic [63:0] acc;
    logic [TIMER_W:0] t;
    r.disable_arc = 1'b0;
    if (b.kind == ITEM_SAMPLE) begin
      if (loop_on) begin
        acc = 64'(avg_fixed) * 64'(settings.weight)
            + 64'({b.adc_sample, {FRAC_W{1'b0}}}) * (64'(WEIGHT_ONE) - 64'(settings.weight));
        avg_fixed = acc[FRAC_W +: FILTER_W];
      end else begin
        avg_fixed = {b.adc_sample, {FRAC_W{1'b0}}};
      end
    end else begin
      r.disable_arc = b.suspended;
      if (b.plasma_on && !b.suspended && settings.setpoint > settings.min_setpoint) begin
        t = arc_ms + b.elapsed_ms;
        arc_ms = (t > TIMER_MAX) ? TIMER_MAX : t[TIMER_W-1:0];
        loop_on = arc_ms > settings.arc_delay;
      end else begin
        arc_ms = '0;
        loop_on = 1'b0;
        steps_held = '0;
      end
      // bang-bang correction, equality keeps the last request
      if (loop_on) begin
        if (avg_fixed > {settings.setpoint, {FRAC_W{1'b0}}}) begin
          steps_held = settings.steps;
          dir_down = 1'b1;
        end else if (avg_fixed < {settings.setpoint, {FRAC_W{1'b0}}}) begin
          steps_held = settings.steps;
          dir_down = 1'b0;
        end
      end
    end
    r.counts  = avg_fixed[FILTER_W-1 -: COUNTS_W];
    r.steps   = steps_held;
    r.down    = dir_down;
    r.running = loop_on;
    return r;
  endfunction

  // offer one beat, gaps first, and log its result once taken
  task automatic send_beat(item_t b, logic typed, thc_result_t want);
    thc_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= b.kind;
    adc_sample <= b.adc_sample;
    plasma_on  <= b.plasma_on;
    suspended  <= b.suspended;
    elapsed_ms <= b.elapsed_ms;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = advance_controller(b);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // stop sending and wait until every result is back and the block has settled
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // write every register, junk in unused upper bits, then one write past the list
  task automatic apply_config(thc_cfg_t c);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    write_reg(REG_SETPOINT, {junk[CFG_DAT_W-1:COUNTS_W], c.setpoint});
    write_reg(REG_MIN_SETPOINT, {junk[COUNTS_W-1 -: (CFG_DAT_W-COUNTS_W)], c.min_setpoint});
    write_reg(REG_ARC_DELAY, c.arc_delay);
    write_reg(REG_WEIGHT, c.weight);
    write_reg(REG_STEPS, {junk[CFG_DAT_W-1:STEPS_W], c.steps});
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_STEPS + 1)),
              CFG_DAT_W'($urandom));
    cfg_write <= 1'b0;
    settings = c;
  endtask

  function automatic thc_cfg_t random_settings(int unsigned phase);
    thc_cfg_t s;
    s.setpoint     = COUNTS_W'($urandom_range(4095, 1));
    s.min_setpoint = COUNTS_W'($urandom_range(s.setpoint - 1, 0));
    s.arc_delay    = DELAY_W'($urandom_range(2000));
    s.weight       = WEIGHT_W'($urandom);
    s.steps        = STEPS_W'($urandom);
    case (phase)
      0: begin
        s.min_setpoint = '0;
        s.arc_delay    = '0;
        s.weight       = '0;
        s.steps        = 8'd1;
      end
      1: begin
        s.arc_delay = DELAY_W'($urandom_range(50));
        s.weight    = '1;
        s.steps     = '1;
      end
      LONG_ARC: begin
        s.setpoint  = '1;
        s.arc_delay = '1;
      end
      NEVER_ARC: begin
        s.min_setpoint = '1;
      end
      5: s.steps = '0;
      6: s.arc_delay = DELAY_W'($urandom);
      default: ;
    endcase
    return s;
  endfunction

  // mostly arc-on sequences with random content, some suspend and plasma-off noise
  function automatic item_t random_beat(logic long_arc);
    item_t b;
    b.kind = ($urandom_range(99) < (long_arc ? 90 : 45)) ? ITEM_CONTROL : ITEM_SAMPLE;
    case ($urandom_range(9))
      0: b.adc_sample = '0;
      1: b.adc_sample = '1;
      2, 3: b.adc_sample = settings.setpoint + COUNTS_W'($urandom_range(2)) - 1'b1;
      default: b.adc_sample = COUNTS_W'($urandom);
    endcase
    b.plasma_on = long_arc || ($urandom_range(99) < 85);
    b.suspended = !long_arc && ($urandom_range(99) < 10);
    if (long_arc) begin
      b.elapsed_ms = ELAPSED_W'($urandom_range(1023, 900));
    end else begin
      case ($urandom_range(5))
        0: b.elapsed_ms = '0;
        1: b.elapsed_ms = '1;
        2, 3: b.elapsed_ms = ELAPSED_W'($urandom_range(20, 1));
        default: b.elapsed_ms = ELAPSED_W'($urandom);
      endcase
    end
    return b;
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    failed = 1'b1;
  endtask

  // result side: random stall, compare each taken beat with the oldest expectation
  always @(posedge clk) begin : result_check
    thc_result_t got;
    thc_result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {filtered_counts, step_request, step_down, loop_running, plasma_disable};
      if (expected_results.size() == 0) begin
        $display("%0t result beat with none expected: %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.counts !== want.counts)
          report_mismatch("filtered_counts", want.counts, got.counts);
        if (got.steps !== want.steps)
          report_mismatch("step_request", want.steps, got.steps);
        if (got.down !== want.down)
          report_mismatch("step_down", want.down, got.down);
        if (got.running !== want.running)
          report_mismatch("loop_running", want.running, got.running);
        if (got.disable_arc !== want.disable_arc)
          report_mismatch("plasma_disable", want.disable_arc, got.disable_arc);
      end
    end
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    send_idle_pct = 25;
    stall_pct     = 25;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].reconfig) begin
        drain();
        apply_config(DIRECTED[i].cfg);
      end
      send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random phases, each with its own settings and idling pattern
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      drain();
      apply_config(random_settings(p));
      for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
        // hold off mid-phase until everything is back
        if (p == PAUSE_PHASE && i == PHASE_BEATS / 2) drain();
        send_beat(random_beat(p == LONG_ARC), 1'b0, '0);
      end
    end

    drain();
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
